// ===== rtl/core/rzopc_pkg.sv =====
// ----------------------------------------------------------------------------
// rzopc_pkg
// Shared field widths, command codes and result limits of the pair counter.
// ----------------------------------------------------------------------------
`default_nettype none

package rzopc_pkg;

  localparam int POS_W  = 10;
  localparam int PAIR_W = 19;

  localparam logic [PAIR_W-1:0] PAIR_MAX = '1;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_TOGGLE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/range_zero_one_pair_counter_top.sv =====
// ----------------------------------------------------------------------------
// range_zero_one_pair_counter_top
// Zero-before-one pair counter over a row of bit positions, kept as a binary
// tree of {zeros, ones, pairs} nodes in one node memory.
// ----------------------------------------------------------------------------
// One word is taken at a time; the node memory has a single read port with a
// registered read. With L = ceil(log2(POSITIONS)) (10 by default): a write
// walks from the leaf up to the root, a toggle reads the leaf first, and a
// query may need a left read and a right read at each tree level. A write or
// toggle to an out-of-range position and command code 3 finish without
// touching the node memory; a toggle of an empty position still reads the
// leaf. After reset a clearing pass writes every node, 2^(L+1) of them (2048
// by default), with item_stall held high. A finished result waits in an
// output register while the next word is taken.
`default_nettype none

module range_zero_one_pair_counter_top
  import rzopc_pkg::*;
#(
  parameter int POSITIONS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [1:0]        command,
  input  logic [POS_W-1:0]  position,
  input  logic              bit_value,
  input  logic [POS_W-1:0]  range_left,
  input  logic [POS_W-1:0]  range_right,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [PAIR_W-1:0] pair_count
);

  localparam int LVL = $clog2(POSITIONS);
  localparam int IW  = LVL + 1;
  localparam int CW  = LVL + 1;
  localparam int NW  = 4 * CW;

  logic              res_load;
  logic              res_free;
  logic [PAIR_W-1:0] res_pairs;
  logic              ram_wen;
  logic [IW-1:0]     ram_waddr;
  logic [NW-1:0]     ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic [NW-1:0]     ram_rdata;
  logic [NW-1:0]     join_a;
  logic [NW-1:0]     join_b;
  logic [NW-1:0]     join_r;

  rzopc_ram #(
    .WIDTH (NW),
    .DEPTH (1 << IW)
  ) u_nodes (
    .clk   (clk),
    .wen   (ram_wen),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rzopc_join #(
    .CW (CW)
  ) u_join (
    .a (join_a),
    .b (join_b),
    .r (join_r)
  );

  rzopc_engine #(
    .POSITIONS (POSITIONS)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .command     (command),
    .position    (position),
    .bit_value   (bit_value),
    .range_left  (range_left),
    .range_right (range_right),
    .res_load    (res_load),
    .res_free    (res_free),
    .res_pairs   (res_pairs),
    .ram_wen     (ram_wen),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .join_a      (join_a),
    .join_b      (join_b),
    .join_r      (join_r)
  );

  assign res_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      pair_count <= res_pairs;
    end
  end

`ifndef SYNTH
  a_clear_after_reset: assert property (@(posedge clk) rst |=> item_stall)
    else $error("item taken during clearing pass");

  a_update_no_result: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && command != CMD_QUERY) |=> !res_load)
    else $error("write or toggle produced a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !res_load)
    else $error("held result overwritten");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    res_load |=> result_valid)
    else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/rzopc_ram.sv =====
// ----------------------------------------------------------------------------
// rzopc_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rzopc_ram #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/rzopc_join.sv =====
// ----------------------------------------------------------------------------
// rzopc_join
// Ordered combine of two tree nodes: counts add, cross pairs from left zeros
// times right ones. Node layout is {pairs, ones, zeros}.
// ----------------------------------------------------------------------------
`default_nettype none

module rzopc_join #(
  parameter int CW = 11
) (
  input  logic [4*CW-1:0] a,
  input  logic [4*CW-1:0] b,
  output logic [4*CW-1:0] r
);

  logic [CW-1:0]   r_zeros;
  logic [CW-1:0]   r_ones;
  logic [2*CW-1:0] cross_pairs;
  logic [2*CW-1:0] r_pairs;

  assign r_zeros     = a[CW-1:0] + b[CW-1:0];
  assign r_ones      = a[2*CW-1:CW] + b[2*CW-1:CW];
  assign cross_pairs = (2*CW)'(a[CW-1:0]) * (2*CW)'(b[2*CW-1:CW]);
  assign r_pairs     = a[4*CW-1:2*CW] + b[4*CW-1:2*CW] + cross_pairs;
  assign r           = {r_pairs, r_ones, r_zeros};

endmodule

`default_nettype wire

// ===== rtl/core/rzopc_engine.sv =====
// ----------------------------------------------------------------------------
// rzopc_engine
// Sequencer over the node memory: clearing pass, leaf update with walk to the
// root, and bottom-up range query with left and right accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module rzopc_engine
  import rzopc_pkg::*;
#(
  parameter int POSITIONS = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic [1:0]                command,
  input  logic [POS_W-1:0]          position,
  input  logic                      bit_value,
  input  logic [POS_W-1:0]          range_left,
  input  logic [POS_W-1:0]          range_right,
  output logic                      res_load,
  input  logic                      res_free,
  output logic [PAIR_W-1:0]         res_pairs,
  output logic                      ram_wen,
  output logic [$clog2(POSITIONS):0] ram_waddr,
  output logic [4*($clog2(POSITIONS)+1)-1:0] ram_wdata,
  output logic [$clog2(POSITIONS):0] ram_raddr,
  input  logic [4*($clog2(POSITIONS)+1)-1:0] ram_rdata,
  output logic [4*($clog2(POSITIONS)+1)-1:0] join_a,
  output logic [4*($clog2(POSITIONS)+1)-1:0] join_b,
  input  logic [4*($clog2(POSITIONS)+1)-1:0] join_r
);

  localparam int LVL = $clog2(POSITIONS);
  localparam int LB  = 1 << LVL;
  localparam int IW  = LVL + 1;
  localparam int CW  = LVL + 1;
  localparam int PW  = 2 * CW;
  localparam int NW  = 4 * CW;
  localparam int XW  = ((POS_W > IW) ? POS_W : IW) + 1;
  localparam int SW  = (PW > PAIR_W) ? PW : PAIR_W;

  localparam logic [NW-1:0] LEAF_ZERO = NW'(1);
  localparam logic [NW-1:0] LEAF_ONE  = NW'(1) << CW;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_TRD,
    S_TCHK,
    S_LEAF,
    S_UP,
    S_QTOP,
    S_QL,
    S_QR,
    S_QFIN
  } state_t;

  state_t        state;
  logic [IW-1:0] idx;
  logic [NW-1:0] cur;
  logic [NW-1:0] accl;
  logic [NW-1:0] accr;
  logic [IW:0]   lo;
  logic [IW:0]   hi;

  logic [XW-1:0] pos_x;
  logic [XW-1:0] left_x;
  logic [XW-1:0] right_x;
  logic [XW-1:0] right_clip;
  logic          pos_ok;
  logic          query_ok;
  logic [IW-1:0] leaf_idx;
  logic [IW-1:0] parent;
  logic [IW:0]   hi_dec;
  logic [IW:0]   lo_inc;
  logic [SW-1:0] pairs_x;

  assign pos_x      = XW'(position);
  assign left_x     = XW'(range_left);
  assign right_x    = XW'(range_right);
  assign pos_ok     = pos_x < XW'(POSITIONS);
  assign right_clip = (right_x >= XW'(POSITIONS)) ? XW'(POSITIONS - 1) : right_x;
  assign query_ok   = left_x <= right_clip;
  assign leaf_idx   = IW'(pos_x) + IW'(LB);
  assign parent     = {1'b0, idx[IW-1:1]};
  assign hi_dec     = hi - (IW+1)'(1);
  assign lo_inc     = lo + (IW+1)'(1);

  assign item_stall = (state != S_IDLE);

  assign pairs_x   = SW'(join_r[NW-1:2*CW]);
  assign res_pairs = (pairs_x > SW'(PAIR_MAX)) ? PAIR_MAX : pairs_x[PAIR_W-1:0];

  always_comb begin
    ram_wen   = 1'b0;
    ram_waddr = idx;
    ram_wdata = cur;
    ram_raddr = idx;
    join_a    = cur;
    join_b    = ram_rdata;
    res_load  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        ram_wen   = 1'b1;
        ram_wdata = '0;
      end
      S_LEAF: begin
        ram_wen   = 1'b1;
        ram_raddr = idx ^ IW'(1);
      end
      S_UP: begin
        ram_wen   = 1'b1;
        ram_waddr = parent;
        ram_wdata = join_r;
        ram_raddr = parent ^ IW'(1);
        if (idx[0]) begin
          join_a = ram_rdata;
          join_b = cur;
        end
      end
      S_QTOP: begin
        ram_raddr = lo[0] ? lo[IW-1:0] : hi_dec[IW-1:0];
      end
      S_QL: begin
        join_a    = accl;
        ram_raddr = hi_dec[IW-1:0];
      end
      S_QR: begin
        join_a = ram_rdata;
        join_b = accr;
      end
      S_QFIN: begin
        join_a   = accl;
        join_b   = accr;
        res_load = res_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx   <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          idx <= idx + IW'(1);
          if (&idx) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            priority if (command == CMD_WRITE) begin
              if (pos_ok) begin
                idx   <= leaf_idx;
                cur   <= bit_value ? LEAF_ONE : LEAF_ZERO;
                state <= S_LEAF;
              end
            end else if (command == CMD_TOGGLE) begin
              if (pos_ok) begin
                idx   <= leaf_idx;
                state <= S_TRD;
              end
            end else if (command == CMD_QUERY) begin
              accl  <= '0;
              accr  <= '0;
              lo    <= (IW+1)'(left_x) + (IW+1)'(LB);
              hi    <= (IW+1)'(right_clip) + (IW+1)'(LB) + (IW+1)'(1);
              state <= query_ok ? S_QTOP : S_QFIN;
            end else begin
            end
          end
        end
        S_TRD: begin
          state <= S_TCHK;
        end
        S_TCHK: begin
          priority if (ram_rdata[CW-1:0] != '0) begin
            cur   <= LEAF_ONE;
            state <= S_LEAF;
          end else if (ram_rdata[2*CW-1:CW] != '0) begin
            cur   <= LEAF_ZERO;
            state <= S_LEAF;
          end else begin
            state <= S_IDLE;
          end
        end
        S_LEAF: begin
          state <= S_UP;
        end
        S_UP: begin
          cur <= join_r;
          idx <= parent;
          if (parent == IW'(1)) begin
            state <= S_IDLE;
          end
        end
        S_QTOP: begin
          priority if (!(lo < hi)) begin
            state <= S_QFIN;
          end else if (lo[0]) begin
            state <= S_QL;
          end else if (hi[0]) begin
            state <= S_QR;
          end else begin
            lo <= lo >> 1;
            hi <= hi >> 1;
          end
        end
        S_QL: begin
          accl <= join_r;
          if (hi[0]) begin
            lo    <= lo_inc;
            state <= S_QR;
          end else begin
            lo    <= lo_inc >> 1;
            hi    <= hi >> 1;
            state <= S_QTOP;
          end
        end
        S_QR: begin
          accr  <= join_r;
          lo    <= lo >> 1;
          hi    <= hi >> 1;
          state <= S_QTOP;
        end
        S_QFIN: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sim/pair_count_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pair_count_checker
// Watches both channels of the pair counter, keeps its own copy of the bit
// row, works out the pair count of every accepted query and compares each
// returned word with the oldest outstanding count.
// ----------------------------------------------------------------------------

module pair_count_checker
  import rzopc_pkg::*;
#(
  parameter int POSITIONS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  logic [1:0]        command,
  input  logic [POS_W-1:0]  position,
  input  logic              bit_value,
  input  logic [POS_W-1:0]  range_left,
  input  logic [POS_W-1:0]  range_right,
  input  logic              result_valid,
  input  logic              result_stall,
  input  logic [PAIR_W-1:0] pair_count,
  output int                fail_count,
  output int                waiting
);

  typedef enum logic [1:0] {
    SLOT_EMPTY,
    SLOT_ZERO,
    SLOT_ONE
  } slot_t;

  slot_t             row [POSITIONS];
  logic [PAIR_W-1:0] outstanding_counts [$];
  int                mismatches = 0;

  function automatic logic [PAIR_W-1:0] pairs_between(input int lo, input int hi);
    longint zeros_seen = 0;
    longint total = 0;
    if (hi > POSITIONS - 1) hi = POSITIONS - 1;
    for (int i = lo; i <= hi; i++) begin
      if (row[i] == SLOT_ZERO) zeros_seen++;
      else if (row[i] == SLOT_ONE) total += zeros_seen;
    end
    if (total > longint'(PAIR_MAX)) total = longint'(PAIR_MAX);
    return total[PAIR_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [PAIR_W-1:0] want;
    if (rst) begin
      foreach (row[i]) row[i] = SLOT_EMPTY;
      outstanding_counts.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (outstanding_counts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pair_count word %0d arrived with no query outstanding", pair_count);
        end else begin
          want = outstanding_counts.pop_front();
          if (pair_count !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pair_count mismatch: expected %0d, actual %0d", want, pair_count);
          end
        end
      end
      if (item_valid && !item_stall) begin
        case (command)
          CMD_WRITE: begin
            if (position < POSITIONS) row[position] = bit_value ? SLOT_ONE : SLOT_ZERO;
          end
          CMD_TOGGLE: begin
            if (position < POSITIONS) begin
              if (row[position] == SLOT_ZERO) row[position] = SLOT_ONE;
              else if (row[position] == SLOT_ONE) row[position] = SLOT_ZERO;
            end
          end
          CMD_QUERY: begin
            outstanding_counts.push_back(pairs_between(int'(range_left), int'(range_right)));
          end
          default: begin
          end
        endcase
      end
    end
    fail_count <= mismatches;
    waiting    <= outstanding_counts.size();
  end

endmodule

// ===== sim/range_zero_one_pair_counter_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_zero_one_pair_counter_top_tb
// Drives writes, toggles and range queries into the pair counter: a short
// directed opening on empty, edge and reversed ranges, a sweep that fills the
// whole row with random queries mixed in, then random traffic. Both sides
// idle in random bursts except at the end; a separate checker predicts and
// compares every pair count.
// ----------------------------------------------------------------------------

module range_zero_one_pair_counter_top_tb;
  import rzopc_pkg::*;

  localparam int         POSITIONS    = 1024;
  localparam int         CYCLE_LIMIT  = 600000;
  localparam int         DRAIN_CYCLES = 64;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic [1:0]        command      = CMD_WRITE;
  logic [POS_W-1:0]  position     = '0;
  logic              bit_value    = 1'b0;
  logic [POS_W-1:0]  range_left   = '0;
  logic [POS_W-1:0]  range_right  = '0;
  logic              result_stall = 1'b0;
  logic              item_stall;
  logic              result_valid;
  logic [PAIR_W-1:0] pair_count;

  int fail_count;
  int waiting;
  int cycle_count = 0;
  int stall_left  = 0;
  bit calm        = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  range_zero_one_pair_counter_top #(
    .POSITIONS(POSITIONS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .command     (command),
    .position    (position),
    .bit_value   (bit_value),
    .range_left  (range_left),
    .range_right (range_right),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .pair_count  (pair_count)
  );

  pair_count_checker #(
    .POSITIONS(POSITIONS)
  ) checker_i (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .command     (command),
    .position    (position),
    .bit_value   (bit_value),
    .range_left  (range_left),
    .range_right (range_right),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .pair_count  (pair_count),
    .fail_count  (fail_count),
    .waiting     (waiting)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("range_zero_one_pair_counter_top_tb failed");
      $finish;
    end
  end

  // hold the result side off in random bursts
  always @(posedge clk) begin
    if (rst || calm) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      result_stall <= 1'b1;
      stall_left   <= $urandom_range(0, 11);
    end else begin
      result_stall <= 1'b0;
    end
  end

  function automatic logic [POS_W-1:0] rand_pos();
    return POS_W'($urandom_range(0, POSITIONS - 1));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic send_word(input logic [1:0] cmd, input logic [POS_W-1:0] pos,
                           input logic b, input logic [POS_W-1:0] lo,
                           input logic [POS_W-1:0] hi);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid  <= 1'b1;
    command     <= cmd;
    position    <= pos;
    bit_value   <= b;
    range_left  <= lo;
    range_right <= hi;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic send_query();
    logic [POS_W-1:0] a;
    logic [POS_W-1:0] b;
    a = rand_pos();
    b = rand_pos();
    if ($urandom_range(0, 3) == 0)
      b = (a > POS_W'(POSITIONS - 17)) ? POS_W'(POSITIONS - 1)
                                       : a + POS_W'($urandom_range(0, 15));
    // mostly ordered ranges, now and then a reversed one
    if (($urandom_range(0, 9) == 0) == (a <= b))
      send_word(CMD_QUERY, rand_pos(), rand_bit(), b, a);
    else
      send_word(CMD_QUERY, rand_pos(), rand_bit(), a, b);
  endtask

  initial begin
    int kind;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_word(CMD_QUERY, '0, 1'b0, '0, '1);
    send_word(CMD_TOGGLE, 10'd5, 1'b1, '0, '0);
    send_word(CMD_QUERY, '0, 1'b0, 10'd5, 10'd5);
    send_word(CMD_WRITE, '0, 1'b0, '1, '1);
    send_word(CMD_WRITE, '1, 1'b1, '0, '0);
    send_word(CMD_QUERY, '1, 1'b1, '0, '1);
    send_word(CMD_QUERY, '0, 1'b0, '1, '0);
    send_word(CMD_QUERY, '0, 1'b0, '1, '1);
    send_word(CMD_TOGGLE, '0, 1'b0, '0, '0);
    send_word(CMD_QUERY, '0, 1'b0, '0, '1);
    send_word(CMD_TOGGLE, '0, 1'b1, '1, '1);
    send_word(CMD_WRITE, 10'd512, 1'b0, '0, '0);
    send_word(CMD_WRITE, 10'd511, 1'b1, '0, '0);
    send_word(CMD_QUERY, '0, 1'b0, '0, '1);
    send_word(CMD_UNUSED, '1, 1'b1, '0, '1);
    send_word(CMD_QUERY, '0, 1'b0, '0, '0);
    send_word(CMD_QUERY, '0, 1'b0, 10'd511, 10'd512);
    send_word(CMD_QUERY, '0, 1'b0, 10'd512, '1);
    send_word(CMD_WRITE, 10'd5, 1'b1, '0, '0);
    send_word(CMD_TOGGLE, 10'd5, 1'b0, '0, '0);
    send_word(CMD_QUERY, '1, 1'b1, '0, 10'd600);

    // fill the row: zeros in the lower half, ones in the upper half
    for (int p = 0; p < POSITIONS; p++) begin
      send_word(CMD_WRITE, p[POS_W-1:0], p >= POSITIONS / 2, rand_pos(), rand_pos());
      if ($urandom_range(0, 7) == 0) send_query();
    end
    send_word(CMD_QUERY, rand_pos(), 1'b1, '0, '1);

    for (int n = 0; n < 450; n++) begin
      if (n == 250) calm <= 1'b1;
      kind = $urandom_range(0, 99);
      if (kind < 30)
        send_word(CMD_WRITE, rand_pos(), rand_bit(), rand_pos(), rand_pos());
      else if (kind < 55)
        send_word(CMD_TOGGLE, rand_pos(), rand_bit(), rand_pos(), rand_pos());
      else if (kind < 93)
        send_query();
      else
        send_word(CMD_UNUSED, rand_pos(), rand_bit(), rand_pos(), rand_pos());
    end
    item_valid <= 1'b0;

    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && waiting == 0)
      $display("range_zero_one_pair_counter_top_tb passed");
    else
      $display("range_zero_one_pair_counter_top_tb failed");
    $finish;
  end

endmodule
